/* rtl/core/eapd_pkg.sv */
// Shared types and constants for the Scale2x pixel doubler.
// No dependencies; eapd_front, eapd_queue, eapd_back and the top level import this package.
`timescale 1ns / 1ps

package eapd_pkg;

    typedef logic [2:0]        idx_t;
    typedef logic [31:0]       color_t;
    typedef logic [7:0][31:0]  palette_t;
    typedef logic [9:0]        col_t;
    typedef logic [2:0]        cfg_idx_t;

    // Register indexes on the configuration port
    localparam cfg_idx_t REG_PALETTE_0   = 3'd0;
    localparam cfg_idx_t REG_PALETTE_1   = 3'd1;
    localparam cfg_idx_t REG_PALETTE_2   = 3'd2;
    localparam cfg_idx_t REG_PALETTE_3   = 3'd3;
    localparam cfg_idx_t REG_IMAGE_WIDTH = 3'd4;

    localparam int PALETTE_PAIRS = 4;
    localparam int WIDTH_REG_W   = 11;
    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd640;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // One classified block: palette indices of the centre and its neighbours, its column and last flag
    typedef struct packed {
        idx_t e;
        idx_t b;
        idx_t d;
        idx_t f;
        idx_t h;
        col_t column;
        logic last;
    } job_t;

endpackage

/* rtl/core/eapd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps

module eapd_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/eapd_front.sv */
// Front end: input handshake, column and row tracking, line stores and job build.
// Depends on eapd_pkg and eapd_ram.
`timescale 1ns / 1ps

module eapd_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  eapd_pkg::idx_t                pixel_index,
    input  logic                          flush_item,
    input  logic [eapd_pkg::WIDTH_REG_W-1:0] image_width,
    input  logic [eapd_pkg::QCOUNT_W-1:0] queue_count,
    output logic                          push,
    output eapd_pkg::job_t                push_job
);

    import eapd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = (AW + 1 > WIDTH_REG_W) ? AW + 1 : WIDTH_REG_W;
    localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);

    // Front state
    logic [AW-1:0] col_reg, col_next;
    logic [1:0]    rows_seen_reg, rows_seen_next;
    idx_t          lnb_reg, lnb_next;

    // Stage after the store reads
    logic          s1_active_reg;
    logic          s1_emit_reg;
    logic          s1_upd_reg;
    logic [AW-1:0] s1_col_reg;
    idx_t          s1_pix_reg;
    logic          s1_flush_reg;
    logic          s1_first_reg;
    logic          s1_zero_reg;
    logic          s1_row_end_reg;
    logic          fwd_hit_reg;
    idx_t          fwd_data_reg;

    logic          accept;
    logic          ignore;
    logic          active;
    logic [EW-1:0] width_ext;
    logic [EW-1:0] w_eff;
    logic [EW-1:0] c_plus1;
    logic          row_end;
    logic [AW-1:0] col_inc;
    logic [AW-1:0] f_addr;
    logic [QCOUNT_W:0] room_use;

    idx_t mid_e_rd;
    idx_t mid_f_rd;
    idx_t upper_rd;
    idx_t upper_wr_data;
    idx_t e_idx;
    idx_t b_idx;
    logic [AW+9:0] col_wide;

    // Reserve a queue slot for every job in flight before taking a transfer
    assign room_use = {1'b0, queue_count} + {{QCOUNT_W{1'b0}}, s1_emit_reg};
    assign in_stall = (room_use >= (QCOUNT_W + 1)'(QUEUE_DEPTH));

    assign accept = in_valid && !in_stall;
    assign ignore = flush_item && (rows_seen_reg == 2'd0);
    assign active = accept && !ignore;

    always_comb
    begin
        width_ext = EW'(image_width);
        if (width_ext == '0)
        begin
            w_eff = EW'(1);
        end
        else if (width_ext > MAX_W)
        begin
            w_eff = MAX_W;
        end
        else
        begin
            w_eff = width_ext;
        end
    end

    assign c_plus1 = EW'(col_reg) + EW'(1);
    assign row_end = (c_plus1 >= w_eff);
    assign col_inc = col_reg + AW'(1);
    assign f_addr  = row_end ? col_reg : col_inc;

    always_comb
    begin
        col_next       = col_reg;
        rows_seen_next = rows_seen_reg;
        if (active)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (flush_item)
                begin
                    rows_seen_next = 2'd0;
                end
                else if (rows_seen_reg != 2'd2)
                begin
                    rows_seen_next = rows_seen_reg + 2'd1;
                end
            end
            else
            begin
                col_next = col_inc;
            end
        end
    end

    // Middle row, two copies so centre and right neighbour read together
    eapd_ram #(.WIDTH(3), .DEPTH(MAX_WIDTH)) u_mid_e (
        .clk     (clk),
        .wr_en   (active && !flush_item),
        .wr_addr (col_reg),
        .wr_data (pixel_index),
        .rd_en   (active),
        .rd_addr (col_reg),
        .rd_data (mid_e_rd)
    );

    eapd_ram #(.WIDTH(3), .DEPTH(MAX_WIDTH)) u_mid_f (
        .clk     (clk),
        .wr_en   (active && !flush_item),
        .wr_addr (col_reg),
        .wr_data (pixel_index),
        .rd_en   (active),
        .rd_addr (f_addr),
        .rd_data (mid_f_rd)
    );

    // Upper row: written in the cycle after the read, from the stage registers, with the old middle entry
    eapd_ram #(.WIDTH(3), .DEPTH(MAX_WIDTH)) u_upper (
        .clk     (clk),
        .wr_en   (s1_upd_reg),
        .wr_addr (s1_col_reg),
        .wr_data (upper_wr_data),
        .rd_en   (active),
        .rd_addr (col_reg),
        .rd_data (upper_rd)
    );

    assign upper_wr_data = s1_first_reg ? s1_pix_reg : mid_e_rd;

    assign e_idx = mid_e_rd;
    assign b_idx = fwd_hit_reg ? fwd_data_reg : upper_rd;

    always_comb
    begin
        lnb_next = lnb_reg;
        if (s1_active_reg)
        begin
            if (s1_flush_reg && s1_row_end_reg)
            begin
                lnb_next = '0;
            end
            else if (s1_first_reg)
            begin
                lnb_next = s1_pix_reg;
            end
            else
            begin
                lnb_next = e_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            rows_seen_reg <= 2'd0;
            lnb_reg       <= '0;
            s1_active_reg <= 1'b0;
            s1_emit_reg   <= 1'b0;
            s1_upd_reg    <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            rows_seen_reg <= rows_seen_next;
            lnb_reg       <= lnb_next;
            s1_active_reg <= active;
            s1_emit_reg   <= active && (rows_seen_reg != 2'd0);
            s1_upd_reg    <= active && !flush_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (active)
        begin
            s1_col_reg     <= col_reg;
            s1_pix_reg     <= pixel_index;
            s1_flush_reg   <= flush_item;
            s1_first_reg   <= (rows_seen_reg == 2'd0);
            s1_zero_reg    <= (col_reg == '0);
            s1_row_end_reg <= row_end;
            // Late upper write landing at this edge on the same entry: bypass it
            fwd_hit_reg    <= s1_upd_reg && (s1_col_reg == col_reg);
            fwd_data_reg   <= upper_wr_data;
        end
    end

    assign col_wide = {10'd0, s1_col_reg};

    always_comb
    begin
        push_job.e      = e_idx;
        push_job.b      = b_idx;
        push_job.d      = s1_zero_reg ? e_idx : lnb_reg;
        push_job.f      = mid_f_rd;
        push_job.h      = s1_flush_reg ? e_idx : s1_pix_reg;
        push_job.column = col_wide[9:0];
        push_job.last   = s1_flush_reg && s1_row_end_reg;
    end

    assign push = s1_emit_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (queue_count < QCOUNT_W'(QUEUE_DEPTH)))
        else $error("job pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        rows_seen_reg != 2'd3)
        else $error("row count beyond saturation");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && flush_item && (rows_seen_reg == 2'd0) |=> !s1_active_reg)
        else $error("early flush started a job");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_emit_reg |-> s1_active_reg && !s1_first_reg)
        else $error("block emitted for the first row");

endmodule

/* rtl/core/eapd_queue.sv */
// Short job queue decoupling the front end from the colour back end.
// Depends on eapd_pkg.
`timescale 1ns / 1ps

module eapd_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  eapd_pkg::job_t                push_job,
    input  logic                          pop,
    output logic                          head_valid,
    output eapd_pkg::job_t                head_job,
    output logic [eapd_pkg::QCOUNT_W-1:0] count
);

    import eapd_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCOUNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCOUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCOUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

/* rtl/core/eapd_back.sv */
// Back end: palette lookup, Scale2x selection and the registered output channel.
// Depends on eapd_pkg.
`timescale 1ns / 1ps

module eapd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  eapd_pkg::job_t    head_job,
    output logic              pop,
    input  eapd_pkg::palette_t palette,
    output logic              out_valid,
    input  logic              out_stall,
    output eapd_pkg::color_t  top_left,
    output eapd_pkg::color_t  top_right,
    output eapd_pkg::color_t  bottom_left,
    output eapd_pkg::color_t  bottom_right,
    output eapd_pkg::col_t    out_column,
    output logic              last_of_image
);

    import eapd_pkg::*;

    logic   load;
    color_t ce, cb, cd, cf, ch;
    color_t tl_next, tr_next, bl_next, br_next;

    logic   out_valid_reg;
    color_t tl_reg, tr_reg, bl_reg, br_reg;
    col_t   column_reg;
    logic   last_reg;

    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = load;

    assign ce = palette[head_job.e];
    assign cb = palette[head_job.b];
    assign cd = palette[head_job.d];
    assign cf = palette[head_job.f];
    assign ch = palette[head_job.h];

    assign tl_next = ((cd == cb) && (cb != cf) && (cd != ch)) ? cd : ce;
    assign tr_next = ((cb == cf) && (cb != cd) && (cf != ch)) ? cf : ce;
    assign bl_next = ((cd == ch) && (cd != cb) && (ch != cf)) ? cd : ce;
    assign br_next = ((ch == cf) && (cd != ch) && (cb != cf)) ? cf : ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tl_reg     <= tl_next;
            tr_reg     <= tr_next;
            bl_reg     <= bl_next;
            br_reg     <= br_next;
            column_reg <= head_job.column;
            last_reg   <= head_job.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign top_left      = tl_reg;
    assign top_right     = tr_reg;
    assign bottom_left   = bl_reg;
    assign bottom_right  = br_reg;
    assign out_column    = column_reg;
    assign last_of_image = last_reg;

endmodule

/* rtl/core/edge_aware_pixel_doubler.sv */
// Top level of the Scale2x pixel doubler: configuration registers and wiring.
// Depends on eapd_pkg, eapd_front, eapd_queue and eapd_back.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): one 3-bit palette index per transfer,
//   in raster order. After the last row send one transfer with flush_item set
//   per column; those emit the bottom row of blocks, the last one flagged by
//   last_of_image.
//   Output channel (out_valid / out_stall): one 2x2 ARGB block per transfer,
//   with its source column. The first source row gives no blocks; every later
//   pixel emits the block of the row above it.
//   Throughput: one input transfer per cycle while in_stall stays low, set by the
//   single write and read per cycle of each line store.
//   Path: store read and job build put the job into the queue, then the queue
//   head is loaded into the output register, where the block is offered.
//   Receiver stall: the output register holds; the four-entry job queue fills,
//   and in_stall rises once queued and in-flight jobs would fill it.
//   Reset: column and row counts clear, palette clears to zero, width goes to
//   640. Line stores are not cleared and are rebuilt by the first row.
//   Configuration writes (cfg_write, cfg_index, cfg_data) belong only in idle
//   periods, between images or between rows.

module edge_aware_pixel_doubler #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  eapd_pkg::cfg_idx_t         cfg_index,
    input  logic [63:0]                cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  eapd_pkg::idx_t             pixel_index,
    input  logic                       flush_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output eapd_pkg::color_t           top_left,
    output eapd_pkg::color_t           top_right,
    output eapd_pkg::color_t           bottom_left,
    output eapd_pkg::color_t           bottom_right,
    output eapd_pkg::col_t             out_column,
    output logic                       last_of_image
);

    import eapd_pkg::*;

    logic [63:0]            pair_reg [PALETTE_PAIRS];
    logic [WIDTH_REG_W-1:0] width_reg;
    palette_t               palette;

    logic                   push;
    job_t                   push_job;
    logic                   pop;
    logic                   head_valid;
    job_t                   head_job;
    logic [QCOUNT_W-1:0]    queue_count;

    // Configuration registers; writes to unused indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PALETTE_PAIRS; k++)
            begin
                pair_reg[k] <= '0;
            end
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PALETTE_0, REG_PALETTE_1, REG_PALETTE_2, REG_PALETTE_3:
                begin
                    pair_reg[cfg_index[1:0]] <= cfg_data;
                end
                REG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_data[WIDTH_REG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Each pair holds the even index in its low half, the odd one in its high half
    for (genvar k = 0; k < PALETTE_PAIRS; k++)
    begin : g_palette
        assign palette[2*k]     = pair_reg[k][31:0];
        assign palette[2*k + 1] = pair_reg[k][63:32];
    end

    // Front: take transfers, track rows, read line stores, build jobs
    eapd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_index (pixel_index),
        .flush_item  (flush_item),
        .image_width (width_reg),
        .queue_count (queue_count),
        .push        (push),
        .push_job    (push_job)
    );

    // Queue: absorb output stalls so the front keeps its pace
    eapd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .count      (queue_count)
    );

    // Back: colour lookup, edge rule and output register
    eapd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .palette       (palette),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .top_left      (top_left),
        .top_right     (top_right),
        .bottom_left   (bottom_left),
        .bottom_right  (bottom_right),
        .out_column    (out_column),
        .last_of_image (last_of_image)
    );

endmodule
